>>> design/esm_pkg.sv
// ----------------------------------------------------------------------------
// Expect string matcher package
// Shared types, codes and pattern helpers of the expect string matcher.
// ----------------------------------------------------------------------------
package esm_pkg;

  localparam int PATTERN_MAX     = 32;
  localparam int RATE_MAX_DIGITS = 6;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 64;

  localparam logic [7:0] DIGIT_RUN = 8'hFF;
  localparam logic [7:0] NUL_SUB   = 8'h7F;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_0    = 8'h30;
  localparam logic [7:0] CHAR_9    = 8'h39;

  localparam logic [CFG_IDX_W-1:0] REG_PAT0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAT3    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PLEN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 3'd5;

  typedef enum logic [1:0] {
    OP_ARM  = 2'd0,
    OP_BYTE = 2'd1,
    OP_TICK = 2'd2,
    OP_NOP  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_WAIT    = 2'd0,
    ST_MATCH   = 2'd1,
    ST_TIMEOUT = 2'd2,
    ST_IDLE    = 2'd3
  } status_e;

  typedef struct packed {
    logic accept;
    logic read;
    logic step;
    logic load;
  } esm_cmd_t;

  typedef struct packed {
    logic need_search;
    logic search_done;
    logic out_free;
  } esm_stat_t;

  function automatic logic [7:0] pat_byte(logic [8*PATTERN_MAX-1:0] pat, logic [4:0] k);
    logic [7:0] b;
    b = pat[8*k +: 8];
    return (b == 8'h00) ? NUL_SUB : b;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CHAR_0) && (c <= CHAR_9);
  endfunction

endpackage

>>> design/esm_in_if.sv
// ----------------------------------------------------------------------------
// Expect string matcher input channel
// Valid/ready channel that carries one operation and one received byte.
// ----------------------------------------------------------------------------
interface esm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] rx_byte;

  modport source (output valid, output operation, output rx_byte, input ready);
  modport sink (input valid, input operation, input rx_byte, output ready);
endinterface

>>> design/esm_out_if.sv
// ----------------------------------------------------------------------------
// Expect string matcher result channel
// Valid/ready channel that carries the status and the captured rate digits.
// ----------------------------------------------------------------------------
interface esm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        autobaud_seen;
  logic [23:0] rate_digits;
  logic [2:0]  rate_digit_count;

  modport source (output valid, output status, output autobaud_seen, output rate_digits,
                  output rate_digit_count, input ready);
  modport sink (input valid, input status, input autobaud_seen, input rate_digits,
                input rate_digit_count, output ready);
endinterface

>>> design/expect_string_matcher_core.sv
// ----------------------------------------------------------------------------
// Expect string matcher core
// Watches received modem bytes for an expect pattern with digit-run capture.
// ----------------------------------------------------------------------------
// Arm, tick, ignored and dropped items skip the search and load the result.
// A byte that starts a search then runs compare steps, each a line store
// read and a compare, over start positions and pattern bytes or digits.
// One item is in work at a time; the next is taken once the result is staged.
// Reset clears control and the pattern; timeout resets to 30; line store stays.
module expect_string_matcher_core #(
  parameter int LINE_DEPTH = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [esm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [esm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  esm_in_if.sink                         item_i,
  esm_out_if.source                      result_o
);
  import esm_pkg::*;

  esm_cmd_t  cmd;
  esm_stat_t stat;

  esm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  esm_datapath #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_op_i        (item_i.operation),
    .in_byte_i      (item_i.rx_byte),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_valid_o    (result_o.valid),
    .out_ready_i    (result_o.ready),
    .out_status_o   (result_o.status),
    .out_autobaud_o (result_o.autobaud_seen),
    .out_rate_o     (result_o.rate_digits),
    .out_count_o    (result_o.rate_digit_count)
  );

endmodule

>>> design/esm_ctrl.sv
// ----------------------------------------------------------------------------
// Expect string matcher controller
// Sequences the accept, line store read, compare step and result load.
// ----------------------------------------------------------------------------
module esm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  esm_pkg::esm_stat_t stat_i,
  output esm_pkg::esm_cmd_t  cmd_o
);
  import esm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_CMP  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = stat_i.need_search ? S_READ : S_DONE;
        end
      end
      S_READ: begin
        cmd_o.read = 1'b1;
        state_d = S_CMP;
      end
      S_CMP: begin
        cmd_o.step = 1'b1;
        state_d = stat_i.search_done ? S_DONE : S_READ;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> design/esm_datapath.sv
// ----------------------------------------------------------------------------
// Expect string matcher datapath
// Configuration, circular line store, pattern walk, digit capture and result.
// ----------------------------------------------------------------------------
module esm_datapath #(
  parameter int LINE_DEPTH = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [esm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [esm_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic [1:0]                        in_op_i,
  input  logic [7:0]                        in_byte_i,
  input  esm_pkg::esm_cmd_t                 cmd_i,
  output esm_pkg::esm_stat_t                stat_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        out_status_o,
  output logic                              out_autobaud_o,
  output logic [23:0]                       out_rate_o,
  output logic [2:0]                        out_count_o
);
  import esm_pkg::*;

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int FW = $clog2(LINE_DEPTH + 1);
  localparam int SW = FW + 1;
  localparam int CW = (FW > 6) ? FW : 6;

  logic [8*PATTERN_MAX-1:0] pat_q, pat_d;
  logic [5:0]  plen_q, plen_d;
  logic [7:0]  timeout_q, timeout_d;
  logic [AW-1:0] head_q, head_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [7:0]  ticks_q, ticks_d;
  logic        armed_q, armed_d;
  logic        flag_q, flag_d;
  logic [23:0] rate_q, rate_d;
  logic [2:0]  count_q, count_d;
  logic        out_valid_q, out_valid_d;

  logic [FW-1:0] start_q, start_d;
  logic [FW-1:0] g_q, g_d;
  logic [5:0]    k_q, k_d;
  logic [2:0]    pos_q, pos_d;
  logic [7:0]    c_q, c_d;
  status_e       res_q, res_d;
  logic [7:0]    rdata_q;

  logic [1:0]    out_status_q;
  logic          out_flag_q;
  logic [23:0]   out_rate_q;
  logic [2:0]    out_count_q;

  logic [7:0]    line_mem [LINE_DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;

  logic [5:0]    plen_eff;
  logic [7:0]    lim;
  logic [7:0]    ticks_inc;
  logic          full;
  logic [FW-1:0] fill_ins;
  logic [7:0]    pb;
  logic          in_line;
  logic          step_hit;
  logic          step_fail;
  logic          last_start;
  logic [2:0]    nib;
  op_e           op;

  function automatic logic [AW-1:0] addr_of(logic [AW-1:0] head, logic [FW-1:0] g);
    logic [SW-1:0] s;
    s = SW'(head) + SW'(g);
    if (s >= SW'(LINE_DEPTH)) begin
      s = s - SW'(LINE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign op        = op_e'(in_op_i);
  assign plen_eff  = (plen_q > 6'(PATTERN_MAX)) ? 6'(PATTERN_MAX) : plen_q;
  assign lim       = (timeout_q == 8'd0) ? 8'd1 : timeout_q;
  assign ticks_inc = (ticks_q == 8'hFF) ? ticks_q : ticks_q + 8'd1;
  assign full      = (fill_q == FW'(LINE_DEPTH));
  assign fill_ins  = full ? fill_q : fill_q + FW'(1);
  assign pb        = pat_byte(pat_q, k_q[4:0]);
  assign in_line   = (g_q < fill_q);
  assign nib       = 3'(RATE_MAX_DIGITS - 1) - pos_q;

  assign stat_o.need_search = (op == OP_BYTE) && armed_q && (in_byte_i != 8'h00)
                              && (plen_eff != 6'd0) && (CW'(fill_ins) >= CW'(plen_eff));
  assign last_start         = ((start_q + FW'(1)) == fill_q);
  assign stat_o.search_done = step_hit || (step_fail && last_start);
  assign stat_o.out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    pat_d       = pat_q;
    plen_d      = plen_q;
    timeout_d   = timeout_q;
    head_d      = head_q;
    fill_d      = fill_q;
    ticks_d     = ticks_q;
    armed_d     = armed_q;
    flag_d      = flag_q;
    rate_d      = rate_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    start_d     = start_q;
    g_d         = g_q;
    k_d         = k_q;
    pos_d       = pos_q;
    c_d         = c_q;
    res_d       = res_q;
    mem_we      = 1'b0;
    mem_waddr   = full ? head_q : addr_of(head_q, fill_q);
    step_hit    = 1'b0;
    step_fail   = 1'b0;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PAT0, REG_PAT1, REG_PAT2, REG_PAT3: begin
          pat_d[64*cfg_idx_i[1:0] +: 64] = cfg_data_i;
        end
        REG_PLEN:    plen_d = cfg_data_i[5:0];
        REG_TIMEOUT: timeout_d = cfg_data_i[7:0];
        default: ;
      endcase
    end

    if (cmd_i.accept) begin
      unique case (op)
        OP_ARM: begin
          fill_d  = '0;
          ticks_d = '0;
          flag_d  = 1'b0;
          rate_d  = '0;
          count_d = '0;
          armed_d = (plen_eff != 6'd0);
          res_d   = (plen_eff == 6'd0) ? ST_MATCH : ST_WAIT;
        end
        OP_NOP: res_d = armed_q ? ST_WAIT : ST_IDLE;
        OP_TICK: begin
          if (!armed_q) begin
            res_d = ST_IDLE;
          end else begin
            ticks_d = ticks_inc;
            res_d   = ST_WAIT;
            if (ticks_inc >= lim) begin
              armed_d = 1'b0;
              res_d   = ST_TIMEOUT;
            end
          end
        end
        OP_BYTE: begin
          if (!armed_q) begin
            res_d = ST_IDLE;
          end else begin
            res_d = ST_WAIT;
            if (in_byte_i != 8'h00) begin
              mem_we  = 1'b1;
              fill_d  = fill_ins;
              c_d     = in_byte_i;
              start_d = '0;
              g_d     = '0;
              k_d     = '0;
              pos_d   = '0;
              if (full) begin
                head_d = (head_q == AW'(LINE_DEPTH - 1)) ? '0 : head_q + AW'(1);
              end
              if (plen_eff == 6'd0) begin
                armed_d = 1'b0;
                res_d   = ST_MATCH;
              end else if (!stat_o.need_search
                           && (in_byte_i == CHAR_CR || in_byte_i == CHAR_LF)) begin
                fill_d = '0;
              end
            end
          end
        end
        default: ;
      endcase
    end

    if (cmd_i.step) begin
      if (pb == DIGIT_RUN) begin
        if (in_line && is_digit(rdata_q)) begin
          flag_d = 1'b1;
          if (pos_q < 3'(RATE_MAX_DIGITS)) begin
            rate_d[4*nib +: 4] = rdata_q[3:0];
            pos_d = pos_q + 3'd1;
          end
          g_d = g_q + FW'(1);
        end else if (!in_line) begin
          if (pos_q > count_q) begin
            count_d = pos_q;
          end
          step_fail = 1'b1;
        end else begin
          count_d = pos_q;
          for (int j = 0; j < RATE_MAX_DIGITS; j++) begin
            if (3'(j) >= pos_q) begin
              rate_d[4*(RATE_MAX_DIGITS-1-j) +: 4] = 4'h0;
            end
          end
          k_d = k_q + 6'd1;
          step_hit = ((k_q + 6'd1) == plen_eff);
        end
      end else if (!in_line || rdata_q != pb) begin
        step_fail = 1'b1;
      end else begin
        g_d = g_q + FW'(1);
        k_d = k_q + 6'd1;
        step_hit = ((k_q + 6'd1) == plen_eff);
      end

      if (step_fail && !last_start) begin
        start_d = start_q + FW'(1);
        g_d     = start_q + FW'(1);
        k_d     = '0;
        pos_d   = '0;
      end

      if (step_hit) begin
        armed_d = 1'b0;
        res_d   = ST_MATCH;
      end else if (step_fail && last_start) begin
        res_d = ST_WAIT;
        if (c_q == CHAR_CR || c_q == CHAR_LF) begin
          fill_d = '0;
        end
      end
    end

    if (cmd_i.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q       <= '0;
      plen_q      <= '0;
      timeout_q   <= 8'd30;
      head_q      <= '0;
      fill_q      <= '0;
      ticks_q     <= '0;
      armed_q     <= 1'b0;
      flag_q      <= 1'b0;
      rate_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pat_q       <= pat_d;
      plen_q      <= plen_d;
      timeout_q   <= timeout_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      ticks_q     <= ticks_d;
      armed_q     <= armed_d;
      flag_q      <= flag_d;
      rate_q      <= rate_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    g_q     <= g_d;
    k_q     <= k_d;
    pos_q   <= pos_d;
    c_q     <= c_d;
    res_q   <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_status_q <= res_q;
      out_flag_q   <= flag_q;
      out_rate_q   <= rate_q;
      out_count_q  <= count_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[mem_waddr] <= in_byte_i;
    end
    if (cmd_i.read) begin
      rdata_q <= line_mem[addr_of(head_q, g_q)];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_status_o   = out_status_q;
  assign out_autobaud_o = out_flag_q;
  assign out_rate_o     = out_rate_q;
  assign out_count_o    = out_count_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(LINE_DEPTH))
    else $error("line fill exceeds the line store depth");

  a_start_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (start_q < fill_q))
    else $error("compare step with a start position outside the line");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 3'(RATE_MAX_DIGITS))
    else $error("captured digit count exceeds the digit limit");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> out_valid_q)
    else $error("result load did not raise the result valid");

endmodule

>>> sim/expect_string_matcher_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Expect string matcher core testbench
// Drives arm, byte, tick and no-op beats under several patterns and timeouts,
// predicts every result beat in a scoreboard and compares each field.
// ----------------------------------------------------------------------------
module expect_string_matcher_core_tb;
  import esm_pkg::*;

  typedef struct {
    status_e     status;
    logic        seen;
    logic [23:0] rate;
    logic [2:0]  count;
  } esm_result_t;

  class match_scoreboard;
    logic [63:0] pat_word[4];
    logic [5:0]  pat_len_reg;
    logic [7:0]  timeout_reg;
    logic [7:0]  line_buf[64];
    int          line_fill;
    int          ticks;
    bit          armed;
    bit          digit_seen;
    logic [23:0] rate_bcd;
    int          rate_count;
    esm_result_t pending[$];
    int          errors;
    int          checked;
    int          match_count;
    int          timeouts;

    function new();
      foreach (pat_word[i]) pat_word[i] = '0;
      pat_len_reg = '0;
      timeout_reg = 8'd30;
      line_fill = 0;
      ticks = 0;
      armed = 0;
      digit_seen = 0;
      rate_bcd = '0;
      rate_count = 0;
      errors = 0;
      checked = 0;
      match_count = 0;
      timeouts = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] data);
      if (idx <= REG_PAT3) pat_word[idx] = data;
      else if (idx == REG_PLEN) pat_len_reg = data[5:0];
      else if (idx == REG_TIMEOUT) timeout_reg = data[7:0];
    endfunction

    function int used_len();
      return (pat_len_reg > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len_reg);
    endfunction

    function logic [7:0] pattern_at(int k);
      logic [7:0] b;
      b = pat_word[k / 8][(k % 8) * 8 +: 8];
      return (b == 8'h00) ? NUL_SUB : b;
    endfunction

    function bit attempt_from(int start);
      int g;
      int pos;
      int n;
      logic [7:0] b;
      g = start;
      pos = 0;
      n = used_len();
      for (int k = 0; k < n; k++) begin
        b = pattern_at(k);
        if (b == DIGIT_RUN) begin
          while (g < line_fill && line_buf[g] >= CHAR_0 && line_buf[g] <= CHAR_9) begin
            digit_seen = 1;
            if (pos < RATE_MAX_DIGITS) begin
              rate_bcd[4 * (RATE_MAX_DIGITS - 1 - pos) +: 4] = 4'(line_buf[g] - CHAR_0);
              pos++;
            end
            g++;
          end
          if (g >= line_fill) begin
            if (pos > rate_count) rate_count = pos;
            return 0;
          end
          rate_count = pos;
          if (pos == 0) rate_bcd = '0;
          else rate_bcd &= 24'hFFFFFF << (4 * (RATE_MAX_DIGITS - pos));
          continue;
        end
        if (g >= line_fill || line_buf[g] != b) return 0;
        g++;
      end
      return 1;
    endfunction

    function void note_item(logic [1:0] op, logic [7:0] c);
      esm_result_t r;
      int lim;
      bit hit;
      r.status = ST_WAIT;
      if (op == OP_ARM) begin
        line_fill = 0;
        ticks = 0;
        digit_seen = 0;
        rate_bcd = '0;
        rate_count = 0;
        if (used_len() == 0) begin
          armed = 0;
          r.status = ST_MATCH;
        end else begin
          armed = 1;
        end
      end else if (op == OP_NOP) begin
        r.status = armed ? ST_WAIT : ST_IDLE;
      end else if (!armed) begin
        r.status = ST_IDLE;
      end else if (op == OP_TICK) begin
        lim = (timeout_reg == 0) ? 1 : int'(timeout_reg);
        if (ticks < 255) ticks++;
        if (ticks >= lim) begin
          armed = 0;
          r.status = ST_TIMEOUT;
        end
      end else if (c != 8'h00) begin
        hit = 0;
        if (line_fill >= 64) begin
          for (int i = 0; i < 63; i++) line_buf[i] = line_buf[i + 1];
          line_fill = 63;
        end
        line_buf[line_fill++] = c;
        if (line_fill >= used_len()) begin
          for (int i = 0; i < line_fill; i++) begin
            if (attempt_from(i)) begin
              hit = 1;
              break;
            end
          end
        end
        if (hit) begin
          armed = 0;
          r.status = ST_MATCH;
        end else if (c == CHAR_LF || c == CHAR_CR) begin
          line_fill = 0;
        end
      end
      r.seen = digit_seen;
      r.rate = rate_bcd;
      r.count = rate_count[2:0];
      pending.push_back(r);
    endfunction

    task report(string what);
      errors++;
      $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task check_result(logic [1:0] st, logic seen, logic [23:0] rate, logic [2:0] count);
      esm_result_t e;
      if (pending.size() == 0) begin
        report("result beat with nothing expected");
        return;
      end
      e = pending.pop_front();
      checked++;
      if (st == ST_MATCH) match_count++;
      if (st == ST_TIMEOUT) timeouts++;
      if (st !== e.status) report($sformatf("status %0d, expected %0d", st, e.status));
      if (seen !== e.seen) report($sformatf("autobaud_seen %0b, expected %0b", seen, e.seen));
      if (rate !== e.rate) report($sformatf("rate_digits %h, expected %h", rate, e.rate));
      if (count !== e.count)
        report($sformatf("rate_digit_count %0d, expected %0d", count, e.count));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [63:0] cfg_data;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          items_sent;

  esm_in_if  in_ch ();
  esm_out_if out_ch ();

  match_scoreboard sb = new();

  expect_string_matcher_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .item_i     (in_ch),
    .result_o   (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.status, out_ch.autobaud_seen, out_ch.rate_digits,
                      out_ch.rate_digit_count);
    out_ch.ready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  task send_item(logic [1:0] op, logic [7:0] c);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.rx_byte   <= c;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_item(op, c);
    items_sent++;
  endtask

  task drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task cfg_write(logic [2:0] idx, logic [63:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task load_pattern(logic [7:0] pat[$], logic [5:0] len_val, logic [7:0] tmo);
    logic [63:0] w[4];
    for (int i = 0; i < 4; i++) w[i] = {$urandom, $urandom};
    foreach (pat[i]) w[i / 8][(i % 8) * 8 +: 8] = pat[i];
    drain();
    for (int i = 0; i < 4; i++) cfg_write(REG_PAT0 + 3'(i), w[i]);
    cfg_write(REG_PLEN, {58'd0, len_val});
    cfg_write(REG_TIMEOUT, {56'd0, tmo});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task feed_pattern(logic [7:0] pat[$]);
    foreach (pat[i]) begin
      if (pat[i] == DIGIT_RUN) begin
        repeat ($urandom_range(0, 8)) send_item(OP_BYTE, 8'(CHAR_0 + $urandom_range(0, 9)));
        if (i == pat.size() - 1) send_item(OP_BYTE, 8'(8'h20 + $urandom_range(0, 15)));
      end else if (pat[i] == 8'h00) begin
        send_item(OP_BYTE, NUL_SUB);
      end else begin
        send_item(OP_BYTE, pat[i]);
      end
    end
  endtask

  function logic [7:0] pick_pattern_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return DIGIT_RUN;
    if (r == 1) return 8'h00;
    return 8'(8'h41 + $urandom_range(0, 25));
  endfunction

  task random_phase(int n_items, int max_len);
    logic [7:0] pat[$];
    int len;
    int t;
    int goal;
    pat = {};
    len = (max_len == PATTERN_MAX) ? PATTERN_MAX : $urandom_range(1, max_len);
    for (int i = 0; i < len; i++) pat.push_back(pick_pattern_byte());
    t = $urandom_range(0, 3);
    load_pattern(pat, (max_len == PATTERN_MAX && $urandom_range(0, 1)) ?
                 6'(32 + $urandom_range(1, 31)) : len[5:0],
                 (t == 0) ? 8'd0 : (t == 1) ? 8'd255 : 8'(3 + $urandom_range(0, 30)));
    goal = items_sent + n_items;
    while (items_sent < goal) begin
      if ($urandom_range(0, 3) != 0) begin
        send_item(OP_ARM, 8'($urandom));
        repeat ($urandom_range(0, 4)) begin
          if ($urandom_range(0, 4) == 0) send_item(OP_TICK, 8'($urandom));
          else send_item(OP_BYTE, 8'($urandom));
        end
        if ($urandom_range(0, 4) == 0) send_item(OP_BYTE, CHAR_CR);
        feed_pattern(pat);
      end else begin
        repeat ($urandom_range(3, 10)) send_item(2'($urandom_range(0, 3)), 8'($urandom));
      end
    end
  endtask

  initial begin
    logic [7:0] pat[$];
    rst_n          = 1'b0;
    cfg_we         <= 1'b0;
    cfg_idx        <= '0;
    cfg_data       <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.operation <= OP_NOP;
    in_ch.rx_byte  <= '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    items_sent     = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset configuration: empty pattern matches on arm; idle beats are ignored.
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_TICK, 8'h00);
    send_item(OP_NOP, 8'h00);
    send_item(OP_ARM, 8'h00);

    pat = {8'h4F, 8'h4B};
    load_pattern(pat, 6'd2, 8'd0);
    send_item(OP_ARM, 8'h00);
    send_item(OP_NOP, 8'h00);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_TICK, 8'h00);
    send_item(OP_ARM, 8'h00);
    send_item(OP_BYTE, 8'h4F);
    send_item(OP_BYTE, CHAR_LF);
    send_item(OP_BYTE, 8'h4F);
    send_item(OP_BYTE, 8'h4B);

    pat = {8'h43, 8'h00, DIGIT_RUN, CHAR_CR};
    load_pattern(pat, 6'd4, 8'd255);
    send_item(OP_ARM, 8'h00);
    send_item(OP_BYTE, 8'h43);
    send_item(OP_BYTE, NUL_SUB);
    for (int i = 0; i < 8; i++) send_item(OP_BYTE, 8'(CHAR_0 + ((i * 7) % 10)));
    send_item(OP_BYTE, CHAR_CR);

    pat = {};
    for (int i = 0; i < PATTERN_MAX; i++) pat.push_back(8'(8'h80 + i));
    load_pattern(pat, 6'd63, 8'd1);
    send_item(OP_ARM, 8'h00);
    for (int i = 0; i < 70; i++) send_item(OP_BYTE, 8'(8'h01 + $urandom_range(0, 253)));
    feed_pattern(pat);
    send_item(OP_TICK, 8'h00);

    random_phase(35, 8);
    send_idle_pct = 64;
    random_phase(35, 6);
    send_idle_pct  = 0;
    recv_stall_pct = 64;
    random_phase(30, PATTERN_MAX);
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    random_phase(35, 5);

    drain();
    $display("covered %0d input beats, %0d results checked, %0d matches, %0d timeouts",
             items_sent, sb.checked, sb.match_count, sb.timeouts);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

>>> sim.f
design/esm_pkg.sv
design/esm_in_if.sv
design/esm_out_if.sv
design/esm_ctrl.sv
design/esm_datapath.sv
design/expect_string_matcher_core.sv
sim/expect_string_matcher_core_tb.sv
